// File: rtl/core/sic_pkg.sv
package sic_pkg;

    localparam int MAX_LEN_DEF = 64;

    localparam logic [2:0] CMD_START    = 3'd0;
    localparam logic [2:0] CMD_APPEND_A = 3'd1;
    localparam logic [2:0] CMD_APPEND_B = 3'd2;
    localparam logic [2:0] CMD_APPEND_C = 3'd3;
    localparam logic [2:0] CMD_FINISH   = 3'd4;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] char_value;
    } t_req;

    typedef struct packed {
        logic is_interleaving;
        logic overflowed;
    } t_rsp;

endpackage

// File: rtl/core/string_interleave_check.sv
// Start, append A and append B update registered state; finish sets a pending flag, then
// registers its result. Append C: an in-place walk over the MAX_LEN+1 reachability cells,
// one per cycle, each reading the A, B and reachability memories once.
// Throughput: one request per cycle, but append C holds off requests until its walk ends and
// finish waits while an earlier result is in flight or stalled.
// Reset (sync, active low): lengths zero, overflow clear, no result pending, no memory cleared.
module string_interleave_check
    import sic_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_req i_in_req,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_rsp o_out_rsp,
    input  logic i_out_stall
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int IW = $clog2(MAX_LEN + 1);
    localparam int CW = $clog2(2 * MAX_LEN + 1);

    logic [IW-1:0] r_a_len;
    logic [IW-1:0] r_b_len;
    logic [CW-1:0] r_c_len;
    logic          r_ovf;
    logic          r_fin_pend;
    logic          r_out_valid;
    t_rsp          r_out_rsp;

    logic          n_accept;
    logic          n_a_room;
    logic          n_b_room;
    logic          n_c_room;
    logic          n_wr_a;
    logic          n_wr_b;
    logic          n_go;
    logic          n_match;

    logic [AW-1:0] w_a_addr;
    logic [AW-1:0] w_b_addr;
    logic [7:0]    w_a_data;
    logic [7:0]    w_b_data;
    logic          w_sel_bit;
    logic          w_busy;

    always_comb begin
        o_in_stall = w_busy
                     || ((r_fin_pend || r_out_valid) && (i_in_req.cmd == CMD_FINISH));
        n_accept   = i_in_valid && !o_in_stall;
        n_a_room   = r_a_len < IW'(MAX_LEN);
        n_b_room   = r_b_len < IW'(MAX_LEN);
        n_c_room   = r_c_len < CW'(2 * MAX_LEN);
        n_wr_a     = n_accept && (i_in_req.cmd == CMD_APPEND_A) && n_a_room;
        n_wr_b     = n_accept && (i_in_req.cmd == CMD_APPEND_B) && n_b_room;
        n_go       = n_accept && (i_in_req.cmd == CMD_APPEND_C) && n_c_room;
        n_match    = (CW'(r_a_len) + CW'(r_b_len)) == r_c_len;
    end

    sic_char_mem #(.MAX_LEN(MAX_LEN)) u_a_mem (
        .i_clk     (i_clk),
        .i_wr_en   (n_wr_a),
        .i_wr_addr (AW'(r_a_len)),
        .i_wr_data (i_in_req.char_value),
        .i_rd_addr (w_a_addr),
        .o_rd_data (w_a_data)
    );

    sic_char_mem #(.MAX_LEN(MAX_LEN)) u_b_mem (
        .i_clk     (i_clk),
        .i_wr_en   (n_wr_b),
        .i_wr_addr (AW'(r_b_len)),
        .i_wr_data (i_in_req.char_value),
        .i_rd_addr (w_b_addr),
        .o_rd_data (w_b_data)
    );

    sic_reach_walk #(.MAX_LEN(MAX_LEN)) u_walk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (n_go),
        .i_ch      (i_in_req.char_value),
        .i_a_len   (r_a_len),
        .i_b_len   (r_b_len),
        .i_k       (r_c_len),
        .o_a_addr  (w_a_addr),
        .o_b_addr  (w_b_addr),
        .i_a_data  (w_a_data),
        .i_b_data  (w_b_data),
        .i_sel_idx (r_a_len),
        .o_sel_bit (w_sel_bit),
        .o_busy    (w_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_len     <= '0;
            r_b_len     <= '0;
            r_c_len     <= '0;
            r_ovf       <= 1'b0;
            r_fin_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_fin_pend) begin
                r_fin_pend  <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (n_accept) begin
                unique case (i_in_req.cmd)
                    CMD_START: begin
                        r_a_len <= '0;
                        r_b_len <= '0;
                        r_c_len <= '0;
                        r_ovf   <= 1'b0;
                    end
                    CMD_APPEND_A: begin
                        if (n_a_room) begin
                            r_a_len <= r_a_len + IW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    CMD_APPEND_B: begin
                        if (n_b_room) begin
                            r_b_len <= r_b_len + IW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    CMD_APPEND_C: begin
                        if (n_c_room) begin
                            r_c_len <= r_c_len + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    CMD_FINISH: begin
                        r_fin_pend <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fin_pend) begin
            r_out_rsp.is_interleaving <= !r_ovf && n_match
                                         && ((r_c_len == '0) || w_sel_bit);
            r_out_rsp.overflowed      <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

// File: rtl/core/sic_char_mem.sv
module sic_char_mem
    import sic_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF,
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [MAX_LEN];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/sic_reach_walk.sv
module sic_reach_walk
    import sic_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF,
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
    localparam int IW = $clog2(MAX_LEN + 1),
    localparam int CW = $clog2(2 * MAX_LEN + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [7:0]    i_ch,
    input  logic [IW-1:0] i_a_len,
    input  logic [IW-1:0] i_b_len,
    input  logic [CW-1:0] i_k,
    output logic [AW-1:0] o_a_addr,
    output logic [AW-1:0] o_b_addr,
    input  logic [7:0]    i_a_data,
    input  logic [7:0]    i_b_data,
    input  logic [IW-1:0] i_sel_idx,
    output logic          o_sel_bit,
    output logic          o_busy
);

    logic              r_reach [MAX_LEN + 1];
    logic              r_rd_bit;
    logic              r_issue;
    logic [IW-1:0]     r_idx;
    logic [CW-1:0]     r_k;
    logic [7:0]        r_ch;
    logic              r_run;
    logic [IW-1:0]     r_cur;
    logic              r_a_ok;
    logic              r_b_ok;
    logic              r_prev_bit;

    logic [IW-1:0]     n_prev;
    logic [CW-1:0]     n_idx_c;
    logic [CW-1:0]     n_j;
    logic              n_in_diag;
    logic              n_a_ok;
    logic              n_b_ok;
    logic [IW-1:0]     n_rd_addr;
    logic              n_cur_bit;
    logic              n_cell;

    always_comb begin
        n_prev    = (r_idx == '0) ? '0 : r_idx - IW'(1);
        n_idx_c   = CW'(r_idx);
        n_in_diag = n_idx_c <= r_k;
        n_j       = r_k - n_idx_c;
        n_a_ok    = n_in_diag && (r_idx != '0) && (r_idx <= i_a_len);
        n_b_ok    = n_in_diag && (n_j < CW'(i_b_len)) && (r_idx <= i_a_len);
        o_a_addr  = AW'(n_prev);
        o_b_addr  = AW'(n_j);
        n_rd_addr = r_issue ? r_idx : i_sel_idx;
        // with no C taken yet the row is bit zero alone
        n_cur_bit = (r_k == '0) ? (r_cur == '0) : r_rd_bit;
        n_cell    = (r_a_ok && r_prev_bit && (i_a_data == r_ch))
                    || (r_b_ok && n_cur_bit && (i_b_data == r_ch));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= 1'b0;
            r_run   <= 1'b0;
        end else begin
            r_run <= r_issue;
            if (i_go) begin
                r_issue <= 1'b1;
            end else if (r_issue && (r_idx == IW'(MAX_LEN))) begin
                r_issue <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_idx <= '0;
            r_k   <= i_k;
            r_ch  <= i_ch;
        end else if (r_issue) begin
            r_idx <= r_idx + IW'(1);
        end
        r_cur  <= r_idx;
        r_a_ok <= n_a_ok;
        r_b_ok <= n_b_ok;
        if (r_run) begin
            r_prev_bit <= n_cur_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_run) begin
            r_reach[r_cur] <= n_cell;
        end
        r_rd_bit <= r_reach[n_rd_addr];
    end

    assign o_sel_bit = r_rd_bit;
    assign o_busy    = r_issue || r_run;

endmodule

// File: verif/interleave_verdict_checker.sv
`timescale 1ns / 1ps

module interleave_verdict_checker
    import sic_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_req i_in_req,
    input  logic i_in_stall,
    input  logic i_out_valid,
    input  t_rsp i_out_rsp,
    input  logic i_out_stall,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_verdicts,
    output int   o_true_verdicts,
    output int   o_overflow_verdicts
);

    logic [7:0]       a_store [MAX_LEN];
    logic [7:0]       b_store [MAX_LEN];
    int               a_len;
    int               b_len;
    int               c_len;
    logic [MAX_LEN:0] reach_row;
    logic             overflow_seen;
    t_rsp             expected_verdicts [$];

    task automatic clear_state();
        a_len = 0;
        b_len = 0;
        c_len = 0;
        reach_row = '0;
        reach_row[0] = 1'b1;
        overflow_seen = 1'b0;
    endtask

    // advance one anti-diagonal against A and B as loaded right now
    task automatic advance_reach(input logic [7:0] ch);
        logic [MAX_LEN:0] next_row;
        int i;
        int j;
        next_row = '0;
        for (i = 0; i <= MAX_LEN && i <= c_len; i++) begin
            j = c_len - i;
            if (i >= 1 && i - 1 < a_len && reach_row[i - 1] && a_store[i - 1] == ch) begin
                next_row[i] = 1'b1;
            end
            if (j < b_len && i <= a_len && reach_row[i] && b_store[j] == ch) begin
                next_row[i] = 1'b1;
            end
        end
        reach_row = next_row;
        c_len++;
    endtask

    task automatic predict_request(input t_req req);
        t_rsp verdict;
        case (req.cmd)
            CMD_START: begin
                clear_state();
            end
            CMD_APPEND_A: begin
                if (a_len < MAX_LEN) begin
                    a_store[a_len] = req.char_value;
                    a_len++;
                end else begin
                    overflow_seen = 1'b1;
                end
            end
            CMD_APPEND_B: begin
                if (b_len < MAX_LEN) begin
                    b_store[b_len] = req.char_value;
                    b_len++;
                end else begin
                    overflow_seen = 1'b1;
                end
            end
            CMD_APPEND_C: begin
                if (c_len < 2 * MAX_LEN) begin
                    advance_reach(req.char_value);
                end else begin
                    overflow_seen = 1'b1;
                end
            end
            CMD_FINISH: begin
                verdict.is_interleaving = !overflow_seen && (a_len + b_len == c_len) &&
                                          reach_row[a_len];
                verdict.overflowed = overflow_seen;
                expected_verdicts.push_back(verdict);
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_verdict(input t_rsp got);
        t_rsp want;
        if (expected_verdicts.size() == 0) begin
            $error("verdict with none pending: is_interleaving=%0b overflowed=%0b",
                   got.is_interleaving, got.overflowed);
            o_fail_count++;
        end else begin
            want = expected_verdicts.pop_front();
            if (got.is_interleaving !== want.is_interleaving) begin
                $error("is_interleaving: expected %0b, actual %0b",
                       want.is_interleaving, got.is_interleaving);
                o_fail_count++;
            end
            if (got.overflowed !== want.overflowed) begin
                $error("overflowed: expected %0b, actual %0b", want.overflowed, got.overflowed);
                o_fail_count++;
            end
            o_verdicts++;
            if (want.is_interleaving) begin
                o_true_verdicts++;
            end
            if (want.overflowed) begin
                o_overflow_verdicts++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            expected_verdicts.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                predict_request(i_in_req);
            end
            if (i_out_valid && !i_out_stall) begin
                check_verdict(i_out_rsp);
            end
        end
        o_pending = expected_verdicts.size();
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import sic_pkg::*;

    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         TARGET_REQS  = 560;
    localparam int         DRAIN_CYCLES = MAX_LEN_DEF + 16;
    localparam logic [2:0] CMD_SPARE_5  = 3'd5;
    localparam logic [2:0] CMD_SPARE_6  = 3'd6;
    localparam logic [2:0] CMD_SPARE_7  = 3'd7;

    logic clk;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_req in_req    = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_rsp out_rsp;

    int fail_count;
    int pending;
    int verdicts;
    int true_verdicts;
    int overflow_verdicts;
    int sent_count  = 0;
    int cycle_count = 0;
    int stall_left  = 0;
    bit no_gaps     = 1'b0;

    logic [7:0] str_a [$];
    logic [7:0] str_b [$];
    logic [7:0] str_c [$];

    always begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    string_interleave_check uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_req    (in_req),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_rsp   (out_rsp),
        .i_out_stall (out_stall)
    );

    interleave_verdict_checker #(
        .MAX_LEN(MAX_LEN_DEF)
    ) u_checker (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .i_in_req            (in_req),
        .i_in_stall          (in_stall),
        .i_out_valid         (out_valid),
        .i_out_rsp           (out_rsp),
        .i_out_stall         (out_stall),
        .o_fail_count        (fail_count),
        .o_pending           (pending),
        .o_verdicts          (verdicts),
        .o_true_verdicts     (true_verdicts),
        .o_overflow_verdicts (overflow_verdicts)
    );

    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < 5) begin
            out_stall  <= 1'b0;
            stall_left <= $urandom_range(100, 300);
        end else if ($urandom_range(0, 99) < 50) begin
            out_stall  <= 1'b0;
            stall_left <= $urandom_range(0, 20);
        end else if ($urandom_range(0, 99) < 85) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end else begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(5, 40);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_char(input bit narrow);
        if (narrow) begin
            return 8'($urandom_range(8'h61, 8'h62));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_req(input logic [2:0] cmd, input logic [7:0] ch);
        int   gap;
        t_req req;
        gap = pick_gap();
        req.cmd = cmd;
        req.char_value = ch;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_req   <= req;
        do @(posedge clk); while (in_stall);
        sent_count++;
    endtask

    task automatic fill_strings(input int la, input int lb, input bit narrow);
        str_a = {};
        str_b = {};
        repeat (la) str_a.push_back(pick_char(narrow));
        repeat (lb) str_b.push_back(pick_char(narrow));
    endtask

    task automatic load_ab();
        int ia;
        int ib;
        ia = 0;
        ib = 0;
        while (ia < str_a.size() || ib < str_b.size()) begin
            if (ib >= str_b.size() || (ia < str_a.size() && $urandom_range(0, 1) == 1)) begin
                send_req(CMD_APPEND_A, str_a[ia]);
                ia++;
            end else begin
                send_req(CMD_APPEND_B, str_b[ib]);
                ib++;
            end
        end
    endtask

    // shuffle A and B into C, keeping order within each
    task automatic merge_strings();
        int ia;
        int ib;
        ia = 0;
        ib = 0;
        str_c = {};
        while (ia < str_a.size() || ib < str_b.size()) begin
            if (ib >= str_b.size() || (ia < str_a.size() && $urandom_range(0, 1) == 1)) begin
                str_c.push_back(str_a[ia]);
                ia++;
            end else begin
                str_c.push_back(str_b[ib]);
                ib++;
            end
        end
    endtask

    task automatic corrupt_c();
        int idx;
        int how;
        how = $urandom_range(0, 2);
        if (str_c.size() == 0 || how == 2) begin
            str_c.push_back(pick_char(1'b1));
        end else begin
            idx = $urandom_range(0, str_c.size() - 1);
            if (how == 0) begin
                str_c[idx] = str_c[idx] ^ 8'(1 << $urandom_range(0, 7));
            end else begin
                str_c.delete(idx);
            end
        end
    endtask

    task automatic send_c();
        foreach (str_c[k]) send_req(CMD_APPEND_C, str_c[k]);
    endtask

    task automatic run_directed();
        send_req(CMD_FINISH, 8'h00);
        send_req(CMD_START, 8'hFF);
        send_req(CMD_APPEND_A, 8'h00);
        send_req(CMD_APPEND_A, 8'hFF);
        send_req(CMD_APPEND_B, 8'hFF);
        send_req(CMD_APPEND_C, 8'hFF);
        send_req(CMD_APPEND_C, 8'h00);
        send_req(CMD_APPEND_C, 8'hFF);
        send_req(CMD_FINISH, 8'hFF);
        send_req(CMD_FINISH, 8'h00);
        send_req(CMD_APPEND_A, 8'h5A);
        send_req(CMD_FINISH, 8'h00);
        send_req(CMD_APPEND_C, 8'h5A);
        send_req(CMD_FINISH, 8'h00);
        send_req(CMD_SPARE_5, 8'hFF);
        send_req(CMD_SPARE_6, 8'h00);
        send_req(CMD_SPARE_7, 8'hA5);
        send_req(CMD_START, 8'h00);
        send_req(CMD_APPEND_C, 8'h41);
        send_req(CMD_FINISH, 8'h00);
        send_req(CMD_START, 8'h00);
        send_req(CMD_APPEND_A, 8'h61);
        send_req(CMD_APPEND_B, 8'h61);
        send_req(CMD_APPEND_C, 8'h61);
        send_req(CMD_APPEND_C, 8'h61);
        send_req(CMD_FINISH, 8'h00);
    endtask

    task automatic run_sequence(input int seq);
        logic [7:0] tail [$];
        int kind;
        int cut;
        kind = $urandom_range(0, 99);
        no_gaps = ($urandom_range(0, 99) < 20);
        if (seq == 3) begin
            // A at capacity, then one past it
            send_req(CMD_START, 8'h00);
            fill_strings(MAX_LEN_DEF, 2, 1'b0);
            load_ab();
            merge_strings();
            send_c();
            send_req(CMD_FINISH, 8'h00);
            send_req(CMD_APPEND_A, pick_char(1'b0));
            send_req(CMD_FINISH, 8'h00);
        end else if (seq == 7) begin
            // B at capacity, then C and B past capacity
            send_req(CMD_START, 8'h00);
            fill_strings(1, MAX_LEN_DEF, 1'b0);
            load_ab();
            merge_strings();
            send_c();
            send_req(CMD_FINISH, 8'h00);
            repeat (MAX_LEN_DEF) send_req(CMD_APPEND_C, pick_char(1'b0));
            send_req(CMD_FINISH, 8'h00);
            send_req(CMD_APPEND_B, pick_char(1'b0));
            send_req(CMD_FINISH, 8'h00);
        end else if (kind < 65) begin
            send_req(CMD_START, pick_char(1'b0));
            fill_strings($urandom_range(0, 6), $urandom_range(0, ($urandom_range(0, 3) == 0) ? 12 : 6),
                         $urandom_range(0, 9) < 7);
            load_ab();
            merge_strings();
            if ($urandom_range(0, 3) == 0) begin
                corrupt_c();
            end
            send_c();
            send_req(CMD_FINISH, pick_char(1'b0));
            if ($urandom_range(0, 4) == 0) begin
                send_req(CMD_FINISH, pick_char(1'b0));
            end
        end else if (kind < 80) begin
            send_req(CMD_START, 8'h00);
            fill_strings($urandom_range(0, 5), $urandom_range(0, 5), 1'b1);
            load_ab();
            str_c = {};
            repeat ($urandom_range(0, str_a.size() + str_b.size() + 1)) begin
                str_c.push_back(pick_char(1'b1));
            end
            send_c();
            send_req(CMD_FINISH, 8'h00);
        end else if (kind < 90) begin
            // load more A and B after part of C has gone by
            send_req(CMD_START, 8'h00);
            fill_strings($urandom_range(0, 4), $urandom_range(0, 4), 1'b1);
            load_ab();
            merge_strings();
            cut = $urandom_range(0, str_c.size());
            for (int k = 0; k < str_c.size(); k++) begin
                if (k < cut) begin
                    send_req(CMD_APPEND_C, str_c[k]);
                end else begin
                    tail.push_back(str_c[k]);
                end
            end
            fill_strings($urandom_range(0, 3), $urandom_range(0, 3), 1'b1);
            load_ab();
            merge_strings();
            foreach (tail[k]) send_req(CMD_APPEND_C, tail[k]);
            send_c();
            send_req(CMD_FINISH, 8'h00);
        end else begin
            repeat ($urandom_range(3, 10)) begin
                send_req(3'($urandom_range(0, 7)), pick_char(1'b0));
            end
        end
    endtask

    initial begin
        int seq;
        seq = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        while (sent_count < TARGET_REQS) begin
            run_sequence(seq);
            seq++;
        end
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d requests in %0d cycles, random sequences: %0d.",
                 sent_count, cycle_count, seq);
        $display("Checked %0d verdicts: %0d true, %0d with overflow.",
                 verdicts, true_verdicts, overflow_verdicts);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d verdicts pending.", cycle_count, pending);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
